// ----- hdl/cscan_pkg.sv -----
// Shared types and constants of the C-SCAN disk request scheduler.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package cscan_pkg;

	// Field widths
	localparam int W_FUNC    = 2;
	localparam int W_OWNER   = 6;
	localparam int W_TRACK   = 16;
	localparam int W_TMO     = 16;
	localparam int W_OUTCOME = 3;

	// Most timeout results one tick may give
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	typedef logic [W_FUNC-1:0]    func_t;
	typedef logic [W_OUTCOME-1:0] outcome_t;

	// Function codes
	localparam func_t FN_REQUEST = 2'd0;
	localparam func_t FN_RELEASE = 2'd1;
	localparam func_t FN_TICK    = 2'd2;

	// Outcome codes
	localparam outcome_t OUT_GRANTED = 3'd0;
	localparam outcome_t OUT_QUEUED  = 3'd1;
	localparam outcome_t OUT_TIMEOUT = 3'd2;
	localparam outcome_t OUT_FULL    = 3'd3;
	localparam outcome_t OUT_IDLE    = 3'd4;

	// One slot word in the slot RAM
	typedef struct packed {
		logic [W_OWNER-1:0] owner;
		logic [W_TRACK-1:0] trk;
		logic [W_TMO-1:0]   rem;
	} slot_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;
		logic scan_step;
		logic finish;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic last_idx;
	} sts_t;

endpackage

// ----- hdl/cscan_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// Holds the slot words of the scheduler. No dependencies.
module cscan_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/cscan_ctrl.sv -----
// Controller state machine of the C-SCAN scheduler: sequences the slot scan.
// Depends on cscan_pkg.
module cscan_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  cscan_pkg::func_t func,
	input  cscan_pkg::sts_t  sts,
	output cscan_pkg::cmd_t  cmd,
	output logic           busy
);
	import cscan_pkg::*;

	state_t state_q;
	state_t state_d;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && (func inside {FN_RELEASE, FN_TICK})) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.last_idx) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Drive commands
	always_comb begin
		cmd.accept    = 1'b0;
		cmd.scan_step = 1'b0;
		cmd.finish    = 1'b0;
		busy          = 1'b1;
		case (state_q)
			ST_IDLE: begin
				cmd.accept = start;
				busy       = 1'b0;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- hdl/cscan_dpath.sv -----
// Datapath of the C-SCAN scheduler: slot store, scan compare, result register.
// Depends on cscan_pkg and cscan_ram.
module cscan_dpath #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cscan_pkg::cmd_t                     cmd,
	output cscan_pkg::sts_t                     sts,
	input  cscan_pkg::func_t                    func,
	input  logic [cscan_pkg::W_OWNER-1:0]       requester,
	input  logic [cscan_pkg::W_TRACK-1:0]       request_track,
	input  logic [cscan_pkg::W_TMO-1:0]         timeout_ms,
	output logic                                strobe,
	output cscan_pkg::outcome_t                 outcome,
	output logic [cscan_pkg::W_OWNER-1:0]       who,
	output logic [cscan_pkg::W_TRACK-1:0]       track,
	output logic                                last
);
	import cscan_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);

	// Control state
	logic [QUEUE_DEPTH-1:0] valid_q, valid_d;
	logic                   busy_q, busy_d;
	logic [W_TRACK-1:0]     cur_q, cur_d;
	func_t                  func_q, func_d;
	logic [AW-1:0]          idx_q, idx_d;
	logic                   rd_vld_s1;
	logic                   up_fnd_q, up_fnd_d;
	logic                   all_fnd_q, all_fnd_d;
	logic                   pend_vld_q, pend_vld_d;
	logic [CNT_W-1:0]       cnt_q, cnt_d;
	logic                   stb_q, stb_d;

	// Payload state
	logic [QUEUE_DEPTH-1:0] upper_q, upper_d;
	logic [AW-1:0]          rd_idx_s1;
	logic [AW-1:0]          up_idx_q, up_idx_d, all_idx_q, all_idx_d;
	logic [W_TRACK-1:0]     up_trk_q, up_trk_d, all_trk_q, all_trk_d;
	logic [W_OWNER-1:0]     up_who_q, up_who_d, all_who_q, all_who_d;
	logic [W_OWNER-1:0]     pend_who_q, pend_who_d;
	logic [W_TRACK-1:0]     pend_trk_q, pend_trk_d;
	outcome_t               oc_q, oc_d;
	logic [W_OWNER-1:0]     who_q, who_d;
	logic [W_TRACK-1:0]     trk_q, trk_d;
	logic                   last_q, last_d;

	// Slot RAM ports
	logic                   we;
	logic [AW-1:0]          waddr;
	slot_t                  wdata;
	logic [$bits(slot_t)-1:0] rdata;
	slot_t                  rd_word;

	// Free slot search
	logic                   free_found;
	logic [AW-1:0]          free_idx;

	cscan_ram #(
		.WIDTH($bits(slot_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.scan_step),
		.raddr(idx_q),
		.rdata(rdata)
	);

	assign rd_word      = slot_t'(rdata);
	assign sts.last_idx = (idx_q == AW'(QUEUE_DEPTH - 1));

	// Find lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = AW'(i);
			end
		end
	end

	// Next state of store, scan and result
	always_comb begin
		valid_d    = valid_q;
		upper_d    = upper_q;
		busy_d     = busy_q;
		cur_d      = cur_q;
		func_d     = func_q;
		idx_d      = idx_q;
		up_fnd_d   = up_fnd_q;
		up_idx_d   = up_idx_q;
		up_trk_d   = up_trk_q;
		up_who_d   = up_who_q;
		all_fnd_d  = all_fnd_q;
		all_idx_d  = all_idx_q;
		all_trk_d  = all_trk_q;
		all_who_d  = all_who_q;
		pend_vld_d = pend_vld_q;
		pend_who_d = pend_who_q;
		pend_trk_d = pend_trk_q;
		cnt_d      = cnt_q;
		stb_d      = 1'b0;
		oc_d       = oc_q;
		who_d      = who_q;
		trk_d      = trk_q;
		last_d     = last_q;
		we         = 1'b0;
		waddr      = free_idx;
		wdata      = '{owner: requester, trk: request_track, rem: timeout_ms};

		// Take a new item; a request completes at once
		if (cmd.accept) begin
			func_d     = func;
			idx_d      = '0;
			up_fnd_d   = 1'b0;
			all_fnd_d  = 1'b0;
			pend_vld_d = 1'b0;
			cnt_d      = '0;
			if (func == FN_REQUEST) begin
				stb_d  = 1'b1;
				last_d = 1'b1;
				who_d  = requester;
				trk_d  = request_track;
				if (!busy_q) begin
					busy_d = 1'b1;
					cur_d  = request_track;
					oc_d   = OUT_GRANTED;
				end else if (free_found) begin
					valid_d[free_idx] = 1'b1;
					upper_d[free_idx] = (request_track >= cur_q);
					we                = 1'b1;
					oc_d              = OUT_QUEUED;
				end else begin
					oc_d = OUT_FULL;
				end
			end
		end

		// Advance scan address
		if (cmd.scan_step) begin
			idx_d = idx_q + 1'b1;
		end

		// Examine the slot read last cycle
		if (rd_vld_s1 && valid_q[rd_idx_s1]) begin
			if (func_q == FN_RELEASE) begin
				if (upper_q[rd_idx_s1] && (!up_fnd_q || rd_word.trk < up_trk_q)) begin
					up_fnd_d = 1'b1;
					up_idx_d = rd_idx_s1;
					up_trk_d = rd_word.trk;
					up_who_d = rd_word.owner;
				end
				if (!all_fnd_q || rd_word.trk < all_trk_q) begin
					all_fnd_d = 1'b1;
					all_idx_d = rd_idx_s1;
					all_trk_d = rd_word.trk;
					all_who_d = rd_word.owner;
				end
			end else if (func_q == FN_TICK && rd_word.rem != '0) begin
				if (rd_word.rem == W_TMO'(1)) begin
					// Drop expired waiter; hold it until the next one tells if it is final
					if (cnt_q < CNT_W'(MAX_RESULTS)) begin
						valid_d[rd_idx_s1] = 1'b0;
						cnt_d              = cnt_q + 1'b1;
						if (pend_vld_q) begin
							stb_d  = 1'b1;
							oc_d   = OUT_TIMEOUT;
							who_d  = pend_who_q;
							trk_d  = pend_trk_q;
							last_d = 1'b0;
						end
						pend_vld_d = 1'b1;
						pend_who_d = rd_word.owner;
						pend_trk_d = rd_word.trk;
					end
				end else begin
					we        = 1'b1;
					waddr     = rd_idx_s1;
					wdata     = rd_word;
					wdata.rem = rd_word.rem - 1'b1;
				end
			end
		end

		// Close the scan: grant, go idle or flush the held timeout
		if (cmd.finish) begin
			if (func_q == FN_RELEASE) begin
				stb_d  = 1'b1;
				last_d = 1'b1;
				if (up_fnd_q) begin
					valid_d[up_idx_q] = 1'b0;
					busy_d            = 1'b1;
					cur_d             = up_trk_q;
					oc_d              = OUT_GRANTED;
					who_d             = up_who_q;
					trk_d             = up_trk_q;
				end else if (all_fnd_q) begin
					// Swap sets: every waiter joins the upper set
					upper_d            = upper_q | valid_q;
					valid_d[all_idx_q] = 1'b0;
					busy_d             = 1'b1;
					cur_d              = all_trk_q;
					oc_d               = OUT_GRANTED;
					who_d              = all_who_q;
					trk_d              = all_trk_q;
				end else begin
					busy_d = 1'b0;
					oc_d   = OUT_IDLE;
					who_d  = '0;
					trk_d  = '0;
				end
			end else if (func_q == FN_TICK && pend_vld_q) begin
				stb_d      = 1'b1;
				oc_d       = OUT_TIMEOUT;
				who_d      = pend_who_q;
				trk_d      = pend_trk_q;
				last_d     = 1'b1;
				pend_vld_d = 1'b0;
			end
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			busy_q     <= 1'b0;
			cur_q      <= '0;
			func_q     <= FN_REQUEST;
			idx_q      <= '0;
			rd_vld_s1  <= 1'b0;
			up_fnd_q   <= 1'b0;
			all_fnd_q  <= 1'b0;
			pend_vld_q <= 1'b0;
			cnt_q      <= '0;
			stb_q      <= 1'b0;
		end else begin
			valid_q    <= valid_d;
			busy_q     <= busy_d;
			cur_q      <= cur_d;
			func_q     <= func_d;
			idx_q      <= idx_d;
			rd_vld_s1  <= cmd.scan_step;
			up_fnd_q   <= up_fnd_d;
			all_fnd_q  <= all_fnd_d;
			pend_vld_q <= pend_vld_d;
			cnt_q      <= cnt_d;
			stb_q      <= stb_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		upper_q    <= upper_d;
		rd_idx_s1  <= idx_q;
		up_idx_q   <= up_idx_d;
		up_trk_q   <= up_trk_d;
		up_who_q   <= up_who_d;
		all_idx_q  <= all_idx_d;
		all_trk_q  <= all_trk_d;
		all_who_q  <= all_who_d;
		pend_who_q <= pend_who_d;
		pend_trk_q <= pend_trk_d;
		oc_q       <= oc_d;
		who_q      <= who_d;
		trk_q      <= trk_d;
		last_q     <= last_d;
	end

	assign strobe  = stb_q;
	assign outcome = oc_q;
	assign who     = who_q;
	assign track   = trk_q;
	assign last    = last_q;

endmodule

// ----- hdl/disk_cscan_request_scheduler.sv -----
// Top level of the C-SCAN disk request scheduler.
// Depends on cscan_pkg, cscan_ctrl, cscan_dpath (and through it cscan_ram).
//
// Usage:
//   Input channel: an item (func, requester, request_track, timeout_ms) is
//   taken at a rising edge with start high and busy low.
//   Result channel: each result shows on outcome, who, track and last for
//   exactly one cycle with strobe high; last marks the final result of the
//   item. The receiver cannot stall the block, so results are never held.
//   Timing:
//   - request: one result in the cycle after acceptance; busy stays low,
//     so a new item can be taken every cycle.
//   - release and tick: the waiter slots are scanned one per cycle through
//     the single read port of the slot RAM; busy is high in the states SCAN,
//     DRAIN and DONE, and the next item is taken once busy is low again.
//     A release gives its single result in the first cycle with busy low; a tick
//     gives its timeouts during the scan, the final one in that same cycle.
//   - function code 3 gives no result and leaves busy low.
//   Reset: the disk is idle, the current track is zero and all slots are
//   empty; slot contents are used only after they are written.
module disk_cscan_request_scheduler #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  cscan_pkg::func_t              func,
	input  logic [cscan_pkg::W_OWNER-1:0] requester,
	input  logic [cscan_pkg::W_TRACK-1:0] request_track,
	input  logic [cscan_pkg::W_TMO-1:0]   timeout_ms,
	output logic                          strobe,
	output cscan_pkg::outcome_t           outcome,
	output logic [cscan_pkg::W_OWNER-1:0] who,
	output logic [cscan_pkg::W_TRACK-1:0] track,
	output logic                          last
);
	import cscan_pkg::*;

	cmd_t cmd;
	sts_t sts;

	cscan_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.func  (func),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy)
	);

	cscan_dpath #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.func         (func),
		.requester    (requester),
		.request_track(request_track),
		.timeout_ms   (timeout_ms),
		.strobe       (strobe),
		.outcome      (outcome),
		.who          (who),
		.track        (track),
		.last         (last)
	);

endmodule

// ----- hdl/cscan_checker.sv -----
// Port level checks of the C-SCAN scheduler, bound to the top level.
// Depends on cscan_pkg and disk_cscan_request_scheduler.
module cscan_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input cscan_pkg::func_t              func,
	input logic                          strobe,
	input cscan_pkg::outcome_t           outcome,
	input logic [cscan_pkg::W_OWNER-1:0] who,
	input logic [cscan_pkg::W_TRACK-1:0] track,
	input logic                          last
);
	import cscan_pkg::*;

	// A request always answers with one final result next cycle
	a_req_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && func == FN_REQUEST |=> strobe && last)
		else $error("request item gave no final result");

	// Release and tick start a scan and answer nothing at once
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (func == FN_RELEASE || func == FN_TICK) |=> busy && !strobe)
		else $error("scan item did not hold busy");

	// A result that is not final shows while the item is still in work
	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("non-final result with item already closed");

	// Disk idle result carries no requester and no track
	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && outcome == OUT_IDLE |-> who == '0 && track == '0 && last)
		else $error("disk idle result with stray fields");

endmodule

bind disk_cscan_request_scheduler cscan_checker u_cscan_checker (.*);
